// ----- src/fct_pkg.sv -----
// ----------------------------------------------------------------------------
// fct_pkg: shared types and constants for the flow cache
// Flow record, classified item and engine state encodings.
// ----------------------------------------------------------------------------
package fct_pkg;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	localparam logic FUNC_PACKET = 1'b0;
	localparam logic FUNC_FLUSH  = 1'b1;

	localparam logic [1:0] REG_ACTIVE   = 2'd0;
	localparam logic [1:0] REG_INACTIVE = 2'd1;
	localparam logic [1:0] REG_LIMIT    = 2'd2;

	localparam logic [15:0] ACTIVE_RST   = 16'd60;
	localparam logic [15:0] INACTIVE_RST = 16'd10;
	localparam logic [5:0]  LIMIT_RST    = 6'd32;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_ip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0]  protocol;
		logic [7:0]  tos;
		logic [31:0] pkts;
		logic [31:0] octets;
		logic [31:0] first_seen;
		logic [31:0] last_seen;
	} flow_t;

	typedef struct packed {
		logic        func;
		logic        pkt_ok;
		logic [31:0] stamp;
		logic [31:0] src_addr;
		logic [31:0] dst_ip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0]  protocol;
		logic [7:0]  tos;
		logic [15:0] ip_length;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MATCH,
		ST_LIMIT,
		ST_FLUSH,
		ST_FINISH
	} eng_state_t;

endpackage

// ----- src/fct_chan_if.sv -----
// ----------------------------------------------------------------------------
// fct channel interfaces
// Header input, flow record output and register write channels.
// ----------------------------------------------------------------------------
interface fct_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] stamp;
	logic [31:0] src_addr;
	logic [31:0] dst_ip;
	logic [15:0] sport;
	logic [15:0] dport;
	logic [7:0]  protocol;
	logic [7:0]  tos;
	logic [15:0] ip_length;
	modport source (output valid, func, stamp, src_addr, dst_ip, sport, dport,
		protocol, tos, ip_length, input ready);
	modport sink (input valid, func, stamp, src_addr, dst_ip, sport, dport,
		protocol, tos, ip_length, output ready);
endinterface

interface fct_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_src_addr;
	logic [31:0] out_dst_addr;
	logic [15:0] out_src_port;
	logic [15:0] out_dst_port;
	logic [7:0]  out_protocol;
	logic [7:0]  out_tos;
	logic [31:0] packet_count;
	logic [31:0] octet_count;
	logic [31:0] first_seen;
	logic [31:0] last_seen;
	logic        last_of_run;
	modport source (output valid, out_src_addr, out_dst_addr, out_src_port, out_dst_port,
		out_protocol, out_tos, packet_count, octet_count, first_seen, last_seen,
		last_of_run, input ready);
	modport sink (input valid, out_src_addr, out_dst_addr, out_src_port, out_dst_port,
		out_protocol, out_tos, packet_count, octet_count, first_seen, last_seen,
		last_of_run, output ready);
endinterface

interface fct_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- src/fct_front.sv -----
// ----------------------------------------------------------------------------
// fct_front: header intake and classification
// Qualifies the protocol, zeroes ICMP ports and queues up to two items.
// ----------------------------------------------------------------------------
module fct_front (
	input  logic           clk,
	input  logic           arst_n,
	fct_in_if.sink         in_ch,
	output fct_pkg::qhead_t head,
	input  logic           pop
);
	import fct_pkg::*;

	item_t      slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	item_t      cls;
	logic       push;
	logic       is_icmp;

	assign is_icmp = in_ch.protocol == PROTO_ICMP;

	always_comb begin
		cls.func      = in_ch.func;
		cls.pkt_ok    = is_icmp || in_ch.protocol == PROTO_TCP || in_ch.protocol == PROTO_UDP;
		cls.stamp     = in_ch.stamp;
		cls.src_addr  = in_ch.src_addr;
		cls.dst_ip    = in_ch.dst_ip;
		cls.sport     = is_icmp ? 16'd0 : in_ch.sport;
		cls.dport     = is_icmp ? 16'd0 : in_ch.dport;
		cls.protocol  = in_ch.protocol;
		cls.tos       = in_ch.tos;
		cls.ip_length = in_ch.ip_length;
	end

	assign in_ch.ready = cnt_q != 2'd2;
	assign push        = in_ch.valid && in_ch.ready;
	assign head.valid  = cnt_q != 2'd0;
	assign head.item   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ----- src/fct_back.sv -----
// ----------------------------------------------------------------------------
// fct_back: flow table engine
// Row of flow cells in insertion order; scans by rotation, exports cell 0.
// ----------------------------------------------------------------------------
module fct_back #(
	parameter int CAPACITY = 32,
	parameter int OW       = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  fct_pkg::qhead_t head,
	output logic            pop,
	input  logic [15:0]     act_to,
	input  logic [15:0]     inact_to,
	input  logic [OW-1:0]   limit,
	output logic [OW-1:0]   occupancy,
	fct_out_if.source       out_ch
);
	import fct_pkg::*;

	flow_t         cell_q [CAPACITY];
	logic [OW-1:0] occ_q;
	logic [OW-1:0] cnt_q;
	item_t         it_q;
	eng_state_t    st_q;
	eng_state_t    st_nxt;
	flow_t         pend_q;
	logic          pend_v_q;
	flow_t         res_q;
	logic          res_last_q;
	logic          res_v_q;

	logic [CAPACITY-1:0] hit;
	logic        any_hit;
	logic [31:0] age;
	logic [31:0] idle;
	logic        expired;
	logic        push_ok;
	logic        emit_ok;
	logic        full;
	logic        do_emit;
	logic        do_rotate;
	logic        do_update;
	logic        do_append;
	logic        do_last;
	flow_t       fresh;

	assign age     = it_q.stamp - cell_q[0].first_seen;
	assign idle    = it_q.stamp - cell_q[0].last_seen;
	assign expired = age >= {16'd0, act_to} || idle >= {16'd0, inact_to};
	assign push_ok = !res_v_q || out_ch.ready;
	assign emit_ok = !pend_v_q || push_ok;
	assign full    = occ_q == OW'(CAPACITY);

	always_comb begin
		for (int i = 0; i < CAPACITY; i++)
			hit[i] = OW'(i) < occ_q
				&& cell_q[i].src_addr == it_q.src_addr && cell_q[i].dst_ip == it_q.dst_ip
				&& cell_q[i].sport == it_q.sport && cell_q[i].dport == it_q.dport
				&& cell_q[i].protocol == it_q.protocol && cell_q[i].tos == it_q.tos;
	end
	assign any_hit = |hit;

	always_comb begin
		fresh.src_addr   = it_q.src_addr;
		fresh.dst_ip     = it_q.dst_ip;
		fresh.sport      = it_q.sport;
		fresh.dport      = it_q.dport;
		fresh.protocol   = it_q.protocol;
		fresh.tos        = it_q.tos;
		fresh.pkts       = 32'd1;
		fresh.octets     = {16'd0, it_q.ip_length};
		fresh.first_seen = it_q.stamp;
		fresh.last_seen  = it_q.stamp;
	end

	// next state
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			ST_IDLE:
				if (head.valid)
					st_nxt = (head.item.func == FUNC_FLUSH) ? ST_FLUSH : ST_SCAN;
			ST_SCAN:
				if (cnt_q == '0)
					st_nxt = ST_MATCH;
			ST_MATCH:
				if (!it_q.pkt_ok || any_hit || !full)
					st_nxt = ST_LIMIT;
			ST_LIMIT:
				if (!(occ_q != '0 && occ_q >= limit) || emit_ok)
					st_nxt = ST_FINISH;
			ST_FLUSH:
				if (occ_q == '0)
					st_nxt = ST_FINISH;
			ST_FINISH:
				if (!pend_v_q || push_ok)
					st_nxt = ST_IDLE;
			default:
				st_nxt = ST_IDLE;
		endcase
	end

	// actions
	always_comb begin
		pop       = 1'b0;
		do_emit   = 1'b0;
		do_rotate = 1'b0;
		do_update = 1'b0;
		do_append = 1'b0;
		do_last   = 1'b0;
		case (st_q)
			ST_IDLE:
				pop = head.valid;
			ST_SCAN:
				if (cnt_q != '0) begin
					if (!expired)
						do_rotate = 1'b1;
					else
						do_emit = emit_ok;
				end
			ST_MATCH:
				if (it_q.pkt_ok) begin
					if (any_hit)
						do_update = 1'b1;
					else if (!full)
						do_append = 1'b1;
					else
						do_emit = emit_ok;
				end
			ST_LIMIT:
				do_emit = occ_q != '0 && occ_q >= limit && emit_ok;
			ST_FLUSH:
				do_emit = occ_q != '0 && emit_ok;
			ST_FINISH:
				do_last = pend_v_q && push_ok;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop)
			it_q <= head.item;
		for (int i = 0; i < CAPACITY; i++) begin
			if (do_emit) begin
				if (i < CAPACITY - 1)
					cell_q[i] <= cell_q[(i + 1) % CAPACITY];
			end else if (do_rotate) begin
				if (OW'(i) == occ_q - 1'b1)
					cell_q[i] <= cell_q[0];
				else if (i < CAPACITY - 1)
					cell_q[i] <= cell_q[(i + 1) % CAPACITY];
			end else if (do_update && hit[i]) begin
				cell_q[i].pkts      <= cell_q[i].pkts + 32'd1;
				cell_q[i].octets    <= cell_q[i].octets + {16'd0, it_q.ip_length};
				cell_q[i].last_seen <= it_q.stamp;
			end else if (do_append && OW'(i) == occ_q) begin
				cell_q[i] <= fresh;
			end
		end
		if (do_emit)
			pend_q <= cell_q[0];
		if ((do_emit && pend_v_q) || do_last) begin
			res_q      <= pend_q;
			res_last_q <= do_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			occ_q    <= '0;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
			res_v_q  <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (do_emit)
				occ_q <= occ_q - 1'b1;
			else if (do_append)
				occ_q <= occ_q + 1'b1;
			if (pop)
				cnt_q <= occ_q;
			else if (do_emit || do_rotate)
				cnt_q <= cnt_q - 1'b1;
			if (do_emit)
				pend_v_q <= 1'b1;
			else if (do_last)
				pend_v_q <= 1'b0;
			if ((do_emit && pend_v_q) || do_last)
				res_v_q <= 1'b1;
			else if (out_ch.ready)
				res_v_q <= 1'b0;
		end
	end

	assign occupancy           = occ_q;
	assign out_ch.valid        = res_v_q;
	assign out_ch.out_src_addr = res_q.src_addr;
	assign out_ch.out_dst_addr = res_q.dst_ip;
	assign out_ch.out_src_port = res_q.sport;
	assign out_ch.out_dst_port = res_q.dport;
	assign out_ch.out_protocol = res_q.protocol;
	assign out_ch.out_tos      = res_q.tos;
	assign out_ch.packet_count = res_q.pkts;
	assign out_ch.octet_count  = res_q.octets;
	assign out_ch.first_seen   = res_q.first_seen;
	assign out_ch.last_seen    = res_q.last_seen;
	assign out_ch.last_of_run  = res_last_q;

endmodule

// ----- src/flow_cache_with_timeouts.sv -----
// ----------------------------------------------------------------------------
// flow_cache_with_timeouts: flow cache with active and inactive timeouts
// Keeps up to CAPACITY IPv4 flows and exports them as flow records.
// ----------------------------------------------------------------------------
//  channel  | dir | moves
//  in_ch    | in  | parsed header or flush request, one per transfer
//  out_ch   | out | exported flow record, last_of_run closes an item's run
//  cfg_ch   | in  | register write: 0 active, 1 inactive timeout, 2 cache limit
//
// A header passes through pop, one scan step per flow plus one to close the
// scan, then match, limit check and a closing step; a miss on a full table
// first exports cell 0, then appends. A flush pops, drains every flow, closes.
// Exports hold the engine only once the pending record and out_ch are both held.
// Reset empties the table at once; no clearing pass. A two-item queue lets
// headers in while the engine works; out_ch stalls hold the engine, then in_ch.
module flow_cache_with_timeouts #(
	parameter int CAPACITY = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	fct_in_if.sink    in_ch,
	fct_out_if.source out_ch,
	fct_cfg_if.sink   cfg_ch
);
	import fct_pkg::*;

	localparam int OW = $clog2(CAPACITY + 1);
	localparam int LW = (OW > 6) ? OW : 6;

	logic [15:0]   act_q;
	logic [15:0]   inact_q;
	logic [5:0]    climit_q;
	logic [LW-1:0] cl_ext;
	logic [OW-1:0] limit;
	logic [OW-1:0] occupancy;
	qhead_t        head;
	logic          pop;

	// registers accept every transfer; unknown indexes are dropped
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= ACTIVE_RST;
			inact_q  <= INACTIVE_RST;
			climit_q <= LIMIT_RST;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_ACTIVE:   act_q    <= cfg_ch.data;
				REG_INACTIVE: inact_q  <= cfg_ch.data;
				REG_LIMIT:    climit_q <= cfg_ch.data[5:0];
				default: ;
			endcase
		end
	end

	// limit of zero behaves as one, above capacity as capacity
	assign cl_ext = LW'(climit_q);
	always_comb begin
		if (cl_ext == '0)
			limit = OW'(1);
		else if (cl_ext > LW'(CAPACITY))
			limit = OW'(CAPACITY);
		else
			limit = OW'(cl_ext);
	end

	fct_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.head   (head),
		.pop    (pop)
	);

	fct_back #(
		.CAPACITY (CAPACITY),
		.OW       (OW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.act_to    (act_q),
		.inact_to  (inact_q),
		.limit     (limit),
		.occupancy (occupancy),
		.out_ch    (out_ch)
	);

	// table never overfills
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= OW'(CAPACITY))
		else $error("occupancy above capacity");

	// flows come and go one at a time
	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy == $past(occupancy) || occupancy == $past(occupancy) + 1'b1
		|| occupancy == $past(occupancy) - 1'b1)
		else $error("occupancy jumped");

endmodule

// ----- tb/flow_cache_with_timeouts_test.sv -----
// ----------------------------------------------------------------------------
// flow_cache_with_timeouts_test: self-checking bench for the flow cache
// Directed table then randomised phases under several register settings;
// every exported flow record is checked against a behavioural flow table or a typed result.
// ----------------------------------------------------------------------------
module flow_cache_with_timeouts_test;
	import fct_pkg::*;

	localparam int CAP      = 32;
	localparam int SETTLE   = 100;  // engine cycles after the last record
	localparam int HOLD_LEN = 300;  // long receiver hold-off

	// one header or flush transfer
	typedef struct {
		logic        func;
		logic [31:0] stamp;
		logic [31:0] src_addr;
		logic [31:0] dst_ip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0]  protocol;
		logic [7:0]  tos;
		logic [15:0] ip_length;
	} hdr_t;

	// one exported record
	typedef struct {
		flow_t f;
		logic  last;
	} rec_t;

	// directed row: n_typed < 0 means the flow table model decides
	typedef struct {
		hdr_t h;
		int   n_typed;
		rec_t r;
	} row_t;

	logic clk;
	logic arst_n;

	fct_in_if  in_ch();
	fct_out_if out_ch();
	fct_cfg_if cfg_ch();

	flow_cache_with_timeouts #(.CAPACITY(CAP)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source),
		.cfg_ch (cfg_ch.sink)
	);

	// behavioural flow table, oldest entry at index 0
	flow_t       flows [CAP];
	int          n_flows;
	logic [15:0] act_to;
	logic [15:0] inact_to;
	logic [5:0]  lim_reg;

	rec_t pending_recs[$];
	int   n_bad;
	int   hold_cnt;
	int   hold_ask;   // bumped by the stimulus to ask for a hold-off
	int   hold_seen;  // last request taken up by the receiver
	bit   calm;  // no random idling on either side while set

	row_t rows[$];

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	initial begin
		#4_000_000;
		$display("status: fail");
		$finish;
	end

	// export entry idx and close the gap
	task automatic export_flow(input int idx);
		rec_t r;
		r.f  = flows[idx];
		r.last = 1'b0;
		pending_recs.push_back(r);
		for (int i = idx; i + 1 < n_flows; i++)
			flows[i] = flows[i + 1];
		n_flows--;
	endtask

	// apply one accepted transfer to the flow table and queue its records
	task automatic track_flows(input hdr_t h);
		int          base;
		int          i;
		int          lim;
		bit          hit;
		logic [15:0] sp;
		logic [15:0] dp;
		base = pending_recs.size();
		if (h.func == FUNC_FLUSH) begin
			while (n_flows > 0)
				export_flow(0);
		end else begin
			i = 0;
			while (i < n_flows) begin
				if ((h.stamp - flows[i].first_seen) >= {16'd0, act_to} ||
				    (h.stamp - flows[i].last_seen) >= {16'd0, inact_to})
					export_flow(i);
				else
					i++;
			end
			if (h.protocol == PROTO_ICMP || h.protocol == PROTO_TCP ||
			    h.protocol == PROTO_UDP) begin
				sp  = (h.protocol == PROTO_ICMP) ? 16'd0 : h.sport;
				dp  = (h.protocol == PROTO_ICMP) ? 16'd0 : h.dport;
				hit = 0;
				for (i = 0; i < n_flows && !hit; i++) begin
					if (flows[i].src_addr == h.src_addr && flows[i].dst_ip == h.dst_ip &&
					    flows[i].sport == sp && flows[i].dport == dp &&
					    flows[i].protocol == h.protocol && flows[i].tos == h.tos) begin
						flows[i].pkts      = flows[i].pkts + 32'd1;
						flows[i].octets    = flows[i].octets + {16'd0, h.ip_length};
						flows[i].last_seen = h.stamp;
						hit = 1;
					end
				end
				if (!hit) begin
					if (n_flows >= CAP)
						export_flow(0);
					flows[n_flows] = '{h.src_addr, h.dst_ip, sp, dp, h.protocol, h.tos,
						32'd1, {16'd0, h.ip_length}, h.stamp, h.stamp};
					n_flows++;
				end
			end
			// clamped cache limit
			lim = (lim_reg == 0) ? 1 : ((lim_reg > CAP) ? CAP : int'(lim_reg));
			if (n_flows > 0 && n_flows >= lim)
				export_flow(0);
		end
		if (pending_recs.size() > base)
			pending_recs[$].last = 1'b1;
	endtask

	// header transfer; returns at the accepting edge
	task automatic offer_hdr(input hdr_t h);
		@(negedge clk);
		in_ch.valid     <= 1'b1;
		in_ch.func      <= h.func;
		in_ch.stamp     <= h.stamp;
		in_ch.src_addr  <= h.src_addr;
		in_ch.dst_ip    <= h.dst_ip;
		in_ch.sport     <= h.sport;
		in_ch.dport     <= h.dport;
		in_ch.protocol  <= h.protocol;
		in_ch.tos       <= h.tos;
		in_ch.ip_length <= h.ip_length;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic idle_sender(input int n);
		@(negedge clk);
		in_ch.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// wait for the block to drain, then let the engine settle
	task automatic drain();
		idle_sender(0);
		while (pending_recs.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_ACTIVE:   act_to   = val;
			REG_INACTIVE: inact_to = val;
			REG_LIMIT:    lim_reg  = val[5:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic add_row(input logic func, input logic [31:0] t, input logic [31:0] sa,
		input logic [31:0] da, input logic [15:0] sp, input logic [15:0] dp,
		input logic [7:0] pr, input logic [7:0] tos, input logic [15:0] len,
		input int n_typed, input flow_t f);
		row_t r;
		r.h       = '{func, t, sa, da, sp, dp, pr, tos, len};
		r.n_typed = n_typed;
		r.r.f     = f;
		r.r.last  = 1'b1;
		rows.push_back(r);
	endtask

	// receiver: random stalls, plus a long hold-off when asked
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ch.ready <= 1'b0;
		end else if (hold_seen != hold_ask) begin
			hold_seen <= hold_ask;
			hold_cnt <= HOLD_LEN - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= calm || ($urandom_range(99) >= 14);
		end
	end

	// record checker
	always @(posedge clk) begin
		rec_t e;
		rec_t a;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			a.f = '{out_ch.out_src_addr, out_ch.out_dst_addr, out_ch.out_src_port,
				out_ch.out_dst_port, out_ch.out_protocol, out_ch.out_tos, out_ch.packet_count,
				out_ch.octet_count, out_ch.first_seen, out_ch.last_seen};
			a.last = out_ch.last_of_run;
			if (pending_recs.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected record %p", a);
			end else begin
				e = pending_recs.pop_front();
				if (a.f.src_addr !== e.f.src_addr || a.f.dst_ip !== e.f.dst_ip ||
				    a.f.sport !== e.f.sport || a.f.dport !== e.f.dport ||
				    a.f.protocol !== e.f.protocol || a.f.tos !== e.f.tos ||
				    a.f.pkts !== e.f.pkts || a.f.octets !== e.f.octets ||
				    a.f.first_seen !== e.f.first_seen || a.f.last_seen !== e.f.last_seen ||
				    a.last !== e.last) begin
					n_bad++;
					if (n_bad <= 10)
						$display("record mismatch: exp %p act %p", e, a);
				end
			end
		end
	end

	// stimulus
	initial begin
		logic [15:0] ph_act [6];
		logic [15:0] ph_inact [6];
		logic [15:0] ph_lim [6];
		hdr_t        pool [8];
		hdr_t        h;
		logic [31:0] now;
		int          base;
		int          r;
		int          k;

		arst_n       = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.func   = FUNC_PACKET;
		in_ch.stamp    = '0; in_ch.src_addr = '0; in_ch.dst_ip = '0;
		in_ch.sport    = '0; in_ch.dport    = '0; in_ch.protocol = '0;
		in_ch.tos      = '0; in_ch.ip_length = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_ACTIVE;
		cfg_ch.data  = '0;
		calm     = 0;
		n_bad    = 0;
		n_flows  = 0;
		act_to   = ACTIVE_RST;
		inact_to = INACTIVE_RST;
		lim_reg  = LIMIT_RST;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part at reset settings
		// flush on an empty table: no records
		add_row(FUNC_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0);
		// extremes of the key and length, then a flush reads it straight back
		add_row(FUNC_PACKET, 100, 32'hFFFF_FFFF, 0, 16'hFFFF, 0, PROTO_TCP, 8'hFF,
			16'hFFFF, -1, '0);
		add_row(FUNC_FLUSH, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 1,
			'{32'hFFFF_FFFF, 0, 16'hFFFF, 0, PROTO_TCP, 8'hFF, 1, 32'h0000_FFFF, 100, 100});
		add_row(FUNC_PACKET, 100, 0, 32'hFFFF_FFFF, 0, 16'hFFFF, PROTO_UDP, 0, 0, -1, '0);
		// ICMP ports read as zero, so the second one is a hit
		add_row(FUNC_PACKET, 200, 32'h0A00_0001, 32'h0A00_0002, 16'h1234, 16'h8000,
			PROTO_ICMP, 8'h10, 64, -1, '0);
		add_row(FUNC_PACKET, 201, 32'h0A00_0001, 32'h0A00_0002, 16'h4321, 16'h0001,
			PROTO_ICMP, 8'h10, 84, -1, '0);
		// ignored protocol, still scans
		add_row(FUNC_PACKET, 202, 1, 2, 3, 4, 8'd2, 0, 99, -1, '0);
		add_row(FUNC_PACKET, 203, 1, 2, 3, 4, 8'hFF, 8'hFF, 99, -1, '0);
		// idle timeout exports the ICMP flow
		add_row(FUNC_PACKET, 300, 32'hC0A8_0101, 32'hC0A8_0102, 53, 4000, PROTO_UDP, 0,
			1500, -1, '0);
		add_row(FUNC_PACKET, 305, 32'hC0A8_0101, 32'hC0A8_0102, 53, 4000, PROTO_UDP, 0,
			1500, -1, '0);
		add_row(FUNC_PACKET, 309, 32'hC0A8_0101, 32'hC0A8_0102, 53, 4000, PROTO_TCP, 0,
			40, -1, '0);
		// active timeout while the flow is kept busy
		for (int i = 0; i < 8; i++)
			add_row(FUNC_PACKET, 312 + 8 * i, 32'hC0A8_0101, 32'hC0A8_0102, 53, 4000,
				PROTO_UDP, 0, 1000, -1, '0);
		// time wraps: across the wrap the difference modulo 2^32 stays small
		add_row(FUNC_PACKET, 32'hFFFF_FFFE, 5, 6, 7, 8, PROTO_TCP, 1, 1, -1, '0);
		add_row(FUNC_PACKET, 32'hFFFF_FFFF, 5, 6, 7, 8, PROTO_TCP, 1, 1, -1, '0);
		add_row(FUNC_PACKET, 32'h0000_0003, 5, 6, 7, 8, PROTO_TCP, 1, 1, -1, '0);
		add_row(FUNC_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, -1, '0);

		foreach (rows[i]) begin
			offer_hdr(rows[i].h);
			base = pending_recs.size();
			track_flows(rows[i].h);
			if (rows[i].n_typed >= 0) begin
				// typed result stands in place of the table model's
				while (pending_recs.size() > base)
					void'(pending_recs.pop_back());
				if (rows[i].n_typed > 0)
					pending_recs.push_back(rows[i].r);
			end
			if ($urandom_range(99) < 14)
				idle_sender($urandom_range(1, 6));
		end
		drain();

		// register settings per phase: reset values, zero timeouts, limit above
		// the table size, limit lowered below occupancy, limit zero, a mid value
		ph_act   = '{16'd60, 16'd0, 16'hFFFF, 16'hFFFF, 16'd300, 16'd120};
		ph_inact = '{16'd10, 16'd0, 16'hFFFF, 16'hFFFF, 16'd20,  16'd30};
		ph_lim   = '{16'd32, 16'd32, 16'h003F, 16'h0002, 16'hFF00, 16'd8};
		now = 32'd1000;

		for (int p = 0; p < 6; p++) begin
			write_reg(REG_ACTIVE, ph_act[p]);
			write_reg(REG_INACTIVE, ph_inact[p]);
			write_reg(REG_LIMIT, ph_lim[p]);
			foreach (pool[j])
				pool[j] = '{FUNC_PACKET, 32'd0, $urandom, $urandom,
					16'($urandom_range(65535)), 16'($urandom_range(65535)), PROTO_TCP,
					8'($urandom_range(255)), 16'd0};
			for (int n = 0; n < 31; n++) begin
				calm = (p == 4);
				// zero timeouts export on every packet, so the block backs up
				if (p == 1 && n == 4)
					hold_ask++;
				r = $urandom_range(99);
				if (r < 5)
					now = now + $urandom_range(0, 200);
				else if (r < 6)
					now = $urandom;
				else
					now = now + $urandom_range(0, 3);
				r = $urandom_range(99);
				k = $urandom_range(7);
				h = pool[k];
				h.stamp     = now;
				h.ip_length = 16'($urandom_range(65535));
				if ($urandom_range(99) < 30) begin
					h.src_addr = $urandom;
					h.dst_ip   = $urandom;
					h.sport    = 16'($urandom_range(65535));
					h.dport    = 16'($urandom_range(65535));
					h.tos      = 8'($urandom_range(255));
				end
				if (r < 4) begin
					h.func = FUNC_FLUSH;
					h.stamp = $urandom;
				end else if (r < 10) begin
					h.protocol = 8'($urandom_range(255));
				end else begin
					case ($urandom_range(2))
						0: h.protocol = PROTO_TCP;
						1: h.protocol = PROTO_UDP;
						default: h.protocol = PROTO_ICMP;
					endcase
				end
				offer_hdr(h);
				track_flows(h);
				if (!calm && $urandom_range(99) < 14)
					idle_sender($urandom_range(1, 8));
			end
			// phase three keeps its table so the next one starts over the limit
			if (p != 2 && p != 5 && $urandom_range(1)) begin
				h = '{FUNC_FLUSH, $urandom, 0, 0, 0, 0, 0, 0, 0};
				offer_hdr(h);
				track_flows(h);
			end
			calm = 0;
			drain();
		end

		h = '{FUNC_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0};
		offer_hdr(h);
		track_flows(h);
		drain();

		if (n_bad == 0 && pending_recs.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
